FILE: hw/rtl/tis_pkg.sv
// Shared types and constants for the trilinear interpolator with spread.
// Used by every module under hw/rtl; no dependencies.
`default_nettype none
package tis_pkg;

   localparam int VALUE_BITS = 24;
   localparam int FRAC_BITS  = 16;
   // eight squares of at most 2^(2*VALUE_BITS) each
   localparam int SUM_BITS   = 2 * VALUE_BITS + 4;
   // divide-by-7 chain handles 8 dividend bits per cell
   localparam int DIV_CELLS  = (SUM_BITS + 7) / 8;
   localparam int DIV_BITS   = DIV_CELLS * 8;
   // z, y, x lerps, squares, two adder levels, divide cells, one cell per root bit
   localparam int LATENCY    = 6 + DIV_CELLS + VALUE_BITS;

   typedef struct packed {
      logic vld;   // request present in this stage
      logic ok;    // all fractions within 0 .. 1.0
      logic sat;   // spread saturates
   } ctl_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] corner_000;
      logic signed [VALUE_BITS-1:0] corner_001;
      logic signed [VALUE_BITS-1:0] corner_010;
      logic signed [VALUE_BITS-1:0] corner_011;
      logic signed [VALUE_BITS-1:0] corner_100;
      logic signed [VALUE_BITS-1:0] corner_101;
      logic signed [VALUE_BITS-1:0] corner_110;
      logic signed [VALUE_BITS-1:0] corner_111;
      logic [FRAC_BITS:0]           frac_x;
      logic [FRAC_BITS:0]           frac_y;
      logic [FRAC_BITS:0]           frac_z;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] interp_value;
      logic [VALUE_BITS-1:0]        spread;
      logic                         valid_res;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/tis_lerp.sv
// One linear interpolation a + floor((b-a)*f / 2^FRAC_BITS).
// Depends on tis_pkg.
`default_nettype none
module tis_lerp (
   input  wire logic signed [tis_pkg::VALUE_BITS-1:0] a,
   input  wire logic signed [tis_pkg::VALUE_BITS-1:0] b,
   input  wire logic [tis_pkg::FRAC_BITS:0]           frac,
   output logic signed [tis_pkg::VALUE_BITS-1:0]      y
);
   localparam int V = tis_pkg::VALUE_BITS;
   localparam int F = tis_pkg::FRAC_BITS;

   logic signed [V:0]       diff;
   logic signed [F+1:0]     fs;
   logic signed [V+F+2:0]   prod;
   logic signed [V+F+2:0]   shifted;

   always_comb begin
      diff    = {b[V-1], b} - {a[V-1], a};
      fs      = {1'b0, frac};
      prod    = diff * fs;
      shifted = prod >>> F;   // floor
      y       = a + shifted[V-1:0];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tis_div7_cell.sv
// Divide-by-7 cell: consumes the top 8 dividend bits, shifts in 8 quotient bits.
// Depends on tis_pkg.
`default_nettype none
module tis_div7_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tis_pkg::ctl_type                  ctl_in,
   input  wire logic signed [tis_pkg::VALUE_BITS-1:0] val_in,
   input  wire logic [tis_pkg::DIV_BITS-1:0]      word_in,
   input  wire logic [2:0]                        rem_in,
   output tis_pkg::ctl_type                       ctl_ff,
   output logic signed [tis_pkg::VALUE_BITS-1:0]  val_ff,
   output logic [tis_pkg::DIV_BITS-1:0]           word_ff,
   output logic [2:0]                             rem_ff
);
   localparam int DW = tis_pkg::DIV_BITS;

   logic [3:0] part;
   logic [2:0] rem_in_w;
   logic [7:0] quo;

   always_comb begin
      rem_in_w = rem_in;
      quo      = '0;
      part     = '0;
      for (int i = 0; i < 8; i++) begin
         part = {rem_in_w, word_in[DW-1-i]};
         if (part >= 4'd7) begin
            quo[7-i] = 1'b1;
            part     = part - 4'd7;
         end
         rem_in_w = part[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      val_ff  <= val_in;
      word_ff <= {word_in[DW-9:0], quo};
      rem_ff  <= rem_in_w;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tis_sqrt_cell.sv
// Integer square root cell: one root bit per cell, restoring method.
// Depends on tis_pkg.
`default_nettype none
module tis_sqrt_cell (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tis_pkg::ctl_type                      ctl_in,
   input  wire logic signed [tis_pkg::VALUE_BITS-1:0] val_in,
   input  wire logic [2*tis_pkg::VALUE_BITS-1:0]      q_in,
   input  wire logic [tis_pkg::VALUE_BITS:0]          rem_in,
   input  wire logic [tis_pkg::VALUE_BITS-1:0]        root_in,
   output tis_pkg::ctl_type                           ctl_ff,
   output logic signed [tis_pkg::VALUE_BITS-1:0]      val_ff,
   output logic [2*tis_pkg::VALUE_BITS-1:0]           q_ff,
   output logic [tis_pkg::VALUE_BITS:0]               rem_ff,
   output logic [tis_pkg::VALUE_BITS-1:0]             root_ff
);
   localparam int V = tis_pkg::VALUE_BITS;

   logic [V+2:0] rem2;
   logic [V+2:0] trial;
   logic [V+2:0] diff;
   logic         ge;

   always_comb begin
      rem2  = {rem_in, q_in[2*V-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = rem2 - trial;
      ge    = rem2 >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      val_ff  <= val_in;
      q_ff    <= {q_in[2*V-3:0], 2'b00};
      rem_ff  <= ge ? diff[V:0] : rem2[V:0];
      root_ff <= {root_in[V-2:0], ge};
   end
endmodule
`default_nettype wire

FILE: hw/rtl/trilinear_interp_with_spread.sv
// Trilinear interpolator with spread estimate: top level.
// Depends on tis_pkg, tis_lerp, tis_div7_cell, tis_sqrt_cell.
//
// Fully pipelined: one request per clock, busy is always low, and each request
// yields exactly one response, rsp_strobe high for one cycle. The receiver
// cannot stall. The pipeline is the chain: three lerp stages (z, y, x), one
// squaring stage, two adder levels, seven divide-by-7 cells (8 bits each) and
// 24 square-root cells (one root bit each). A fraction above 1.0 gives
// valid_res 0 with zero value and spread. The spread saturates to all ones.
`default_nettype none
module trilinear_interp_with_spread (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tis_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tis_pkg::rsp_type      rsp_data
);
   localparam int V  = tis_pkg::VALUE_BITS;
   localparam int F  = tis_pkg::FRAC_BITS;
   localparam int SW = tis_pkg::SUM_BITS;
   localparam int DC = tis_pkg::DIV_CELLS;
   localparam int DW = tis_pkg::DIV_BITS;

   assign busy = 1'b0;

   logic signed [V-1:0] corner [8];
   logic                in_ok;

   always_comb begin
      corner[0] = req_data.corner_000;
      corner[1] = req_data.corner_001;
      corner[2] = req_data.corner_010;
      corner[3] = req_data.corner_011;
      corner[4] = req_data.corner_100;
      corner[5] = req_data.corner_101;
      corner[6] = req_data.corner_110;
      corner[7] = req_data.corner_111;
      // fraction above 1.0: top bit set with any lower bit
      in_ok = !((req_data.frac_x[F] && (|req_data.frac_x[F-1:0])) ||
                (req_data.frac_y[F] && (|req_data.frac_y[F-1:0])) ||
                (req_data.frac_z[F] && (|req_data.frac_z[F-1:0])));
   end

   // ---- stage 1: four lerps along z
   logic signed [V-1:0] cz     [4];
   logic signed [V-1:0] cz_ff  [4];
   logic signed [V-1:0] c1_ff  [8];
   logic [F:0]          fx1_ff, fy1_ff;
   tis_pkg::ctl_type    ctl1_ff;

   for (genvar g = 0; g < 4; g++) begin : g_lz
      tis_lerp u_lerp (.a(corner[2*g]), .b(corner[2*g+1]), .frac(req_data.frac_z),
                       .y(cz[g]));
   end

   // ---- stage 2: two lerps along y
   logic signed [V-1:0] cy     [2];
   logic signed [V-1:0] cy_ff  [2];
   logic signed [V-1:0] c2_ff  [8];
   logic [F:0]          fx2_ff;
   tis_pkg::ctl_type    ctl2_ff;

   for (genvar g = 0; g < 2; g++) begin : g_ly
      tis_lerp u_lerp (.a(cz_ff[2*g]), .b(cz_ff[2*g+1]), .frac(fy1_ff), .y(cy[g]));
   end

   // ---- stage 3: final lerp along x
   logic signed [V-1:0] rx;
   logic signed [V-1:0] r3_ff;
   logic signed [V-1:0] c3_ff  [8];
   tis_pkg::ctl_type    ctl3_ff;

   tis_lerp u_lerp_x (.a(cy_ff[0]), .b(cy_ff[1]), .frac(fx2_ff), .y(rx));

   // ---- stage 4: squared differences
   logic signed [V:0]   dif    [8];
   logic [V:0]          mag    [8];
   logic [2*V+1:0]      sq     [8];
   logic [SW-1:0]       sq_ff  [8];
   logic signed [V-1:0] r4_ff;
   tis_pkg::ctl_type    ctl4_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         dif[i] = {c3_ff[i][V-1], c3_ff[i]} - {r3_ff[V-1], r3_ff};
         mag[i] = dif[i][V] ? (V+1)'(-dif[i]) : (V+1)'(dif[i]);
         sq[i]  = mag[i] * mag[i];
      end
   end

   // ---- stage 5: two partial sums; stage 6: total and saturation check
   logic [SW-1:0]       half_ff [2];
   logic signed [V-1:0] r5_ff;
   tis_pkg::ctl_type    ctl5_ff;
   logic [SW-1:0]       total;
   tis_pkg::ctl_type    ctl5_sat;
   logic [SW-1:0]       total_ff;
   logic signed [V-1:0] r6_ff;
   tis_pkg::ctl_type    ctl6_ff;

   always_comb begin
      total        = half_ff[0] + half_ff[1];
      ctl5_sat     = ctl5_ff;
      ctl5_sat.sat = total >= (SW'(7) << (2*V));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else begin
         ctl1_ff <= '{vld: start, ok: in_ok, sat: 1'b0};
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_sat;
      end
      for (int i = 0; i < 8; i++) begin
         c1_ff[i] <= corner[i];
         c2_ff[i] <= c1_ff[i];
         c3_ff[i] <= c2_ff[i];
         sq_ff[i] <= SW'(sq[i]);
      end
      for (int i = 0; i < 4; i++) cz_ff[i] <= cz[i];
      fx1_ff     <= req_data.frac_x;
      fy1_ff     <= req_data.frac_y;
      cy_ff[0]   <= cy[0];
      cy_ff[1]   <= cy[1];
      fx2_ff     <= fx1_ff;
      r3_ff      <= rx;
      r4_ff      <= r3_ff;
      half_ff[0] <= sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      half_ff[1] <= sq_ff[4] + sq_ff[5] + sq_ff[6] + sq_ff[7];
      r5_ff      <= r4_ff;
      total_ff   <= total;
      r6_ff      <= r5_ff;
   end

   // ---- divide-by-7 chain, quotient replaces the dividend 8 bits per cell
   tis_pkg::ctl_type    d_ctl  [DC+1];
   logic signed [V-1:0] d_val  [DC+1];
   logic [DW-1:0]       d_word [DC+1];
   logic [2:0]          d_rem  [DC+1];

   assign d_ctl[0]  = ctl6_ff;
   assign d_val[0]  = r6_ff;
   assign d_word[0] = DW'(total_ff);
   assign d_rem[0]  = '0;

   for (genvar g = 0; g < DC; g++) begin : g_div
      tis_div7_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_in (d_ctl[g]),
         .val_in (d_val[g]),
         .word_in(d_word[g]),
         .rem_in (d_rem[g]),
         .ctl_ff (d_ctl[g+1]),
         .val_ff (d_val[g+1]),
         .word_ff(d_word[g+1]),
         .rem_ff (d_rem[g+1])
      );
   end

   // ---- square-root chain, one root bit per cell
   tis_pkg::ctl_type    s_ctl  [V+1];
   logic signed [V-1:0] s_val  [V+1];
   logic [2*V-1:0]      s_q    [V+1];
   logic [V:0]          s_rem  [V+1];
   logic [V-1:0]        s_root [V+1];

   // when not saturating the quotient is below 2^(2*VALUE_BITS)
   assign s_ctl[0]  = d_ctl[DC];
   assign s_val[0]  = d_val[DC];
   assign s_q[0]    = d_word[DC][2*V-1:0];
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar g = 0; g < V; g++) begin : g_sqrt
      tis_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_in (s_ctl[g]),
         .val_in (s_val[g]),
         .q_in   (s_q[g]),
         .rem_in (s_rem[g]),
         .root_in(s_root[g]),
         .ctl_ff (s_ctl[g+1]),
         .val_ff (s_val[g+1]),
         .q_ff   (s_q[g+1]),
         .rem_ff (s_rem[g+1]),
         .root_ff(s_root[g+1])
      );
   end

   // ---- response
   always_comb begin
      rsp_strobe = s_ctl[V].vld;
      if (s_ctl[V].ok) begin
         rsp_data.interp_value = s_val[V];
         rsp_data.spread       = s_ctl[V].sat ? {V{1'b1}} : s_root[V];
         rsp_data.valid_res    = 1'b1;
      end else begin
         rsp_data = '0;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tis_checker.sv
// Port-level checks for the trilinear interpolator, bound to the top level.
// Depends on tis_pkg and trilinear_interp_with_spread.
`default_nettype none
module tis_port_checks (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire tis_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire tis_pkg::rsp_type rsp_data
);
   localparam int F = tis_pkg::FRAC_BITS;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(tis_pkg::LATENCY) rsp_strobe)
      else $error("request without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##(tis_pkg::LATENCY) !rsp_strobe)
      else $error("response without request");

   a_bad_frac: assert property (@(posedge clock) disable iff (reset)
      (start && req_data.frac_x[F] && (|req_data.frac_x[F-1:0]))
      |-> ##(tis_pkg::LATENCY) (!rsp_data.valid_res && rsp_data.interp_value == '0
                                && rsp_data.spread == '0))
      else $error("out-of-range fraction not flagged");
endmodule

bind trilinear_interp_with_spread tis_port_checks u_tis_port_checks (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: tb/sv/tis_checker.sv
// Checker for the trilinear interpolator: watches requests and responses,
// predicts each response and compares it field by field. Depends on tis_pkg.
`default_nettype none
module tis_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire tis_pkg::req_type req_data,
   input  wire logic             rsp_strobe,
   input  wire tis_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   localparam int VB = tis_pkg::VALUE_BITS;
   localparam int FB = tis_pkg::FRAC_BITS;
   localparam longint ONE = longint'(1) << FB;
   localparam logic [VB-1:0] SPREAD_MAX = '1;

   tis_pkg::rsp_type expected_rsp_q[$];

   function automatic longint lerp_trunc(longint a, longint b, longint f);
      longint s;
      s = a * (ONE - f) + b * f;
      return s >>> FB;   // floor
   endfunction

   function automatic tis_pkg::rsp_type interp_predict(tis_pkg::req_type r);
      tis_pkg::rsp_type o;
      longint     c[8];
      longint     fx, fy, fz, z0, z1, z2, z3, y0, y1, v, d;
      logic [63:0] sum;
      logic [63:0] q, root;
      c[0] = longint'(r.corner_000); c[1] = longint'(r.corner_001);
      c[2] = longint'(r.corner_010); c[3] = longint'(r.corner_011);
      c[4] = longint'(r.corner_100); c[5] = longint'(r.corner_101);
      c[6] = longint'(r.corner_110); c[7] = longint'(r.corner_111);
      fx = longint'(r.frac_x); fy = longint'(r.frac_y); fz = longint'(r.frac_z);
      o = '0;
      if (fx > ONE || fy > ONE || fz > ONE)
         return o;
      z0 = lerp_trunc(c[0], c[1], fz);
      z1 = lerp_trunc(c[2], c[3], fz);
      z2 = lerp_trunc(c[4], c[5], fz);
      z3 = lerp_trunc(c[6], c[7], fz);
      y0 = lerp_trunc(z0, z1, fy);
      y1 = lerp_trunc(z2, z3, fy);
      v = lerp_trunc(y0, y1, fx);
      // differences fit 25 bits, squares 50 bits, sum well under 64 bits
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         d = c[i] - v;
         sum += 64'(d * d);
      end
      q = sum / 64'd7;
      if (q >= (64'd1 << (2 * VB))) begin
         o.spread = SPREAD_MAX;
      end else begin
         root = '0;
         for (int b = 31; b >= 0; b--)
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= q)
               root |= 64'd1 << b;
         o.spread = (root > 64'(SPREAD_MAX)) ? SPREAD_MAX : root[VB-1:0];
      end
      o.interp_value = v[VB-1:0];
      o.valid_res = 1'b1;
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   assign pending = expected_rsp_q.size();

   always @(posedge clock) begin
      tis_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_data.interp_value !== e.interp_value)
                  report_mismatch($sformatf("interp_value %h, want %h",
                     rsp_data.interp_value, e.interp_value));
               if (rsp_data.spread !== e.spread)
                  report_mismatch($sformatf("spread %h, want %h",
                     rsp_data.spread, e.spread));
               if (rsp_data.valid_res !== e.valid_res)
                  report_mismatch($sformatf("valid_res %b, want %b",
                     rsp_data.valid_res, e.valid_res));
            end
         end
         if (start && !busy)
            expected_rsp_q.push_back(interp_predict(req_data));
      end else begin
         fail_count = 0;
      end
   end
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Top of the trilinear interpolator testbench: clock, reset, request stimulus
// and verdict. Depends on tis_pkg, tis_checker and trilinear_interp_with_spread.
`default_nettype none
module tb;
   localparam int VW = tis_pkg::VALUE_BITS;
   localparam int FW = tis_pkg::FRAC_BITS + 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [FW-1:0] FRAC_ONE = FW'(1) << tis_pkg::FRAC_BITS;
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tis_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   tis_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               idle_pct = 0;   // chance in percent that the sender skips a cycle
   int               stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trilinear_interp_with_spread dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   tis_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   // watchdog: cycles with no request and no response accepted
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [FW-1:0] rand_frac();
      // mostly valid, with the edges 0 and 1.0 and some over-range values
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return FRAC_ONE;
         2:       return FW'($urandom_range(int'(FRAC_ONE) + 1, (1 << FW) - 1));
         default: return FW'($urandom_range(0, int'(FRAC_ONE)));
      endcase
   endfunction

   function automatic logic signed [VW-1:0] rand_corner(int mode);
      case (mode)
         0:       return ($urandom_range(0, 1)) ? VMAX : VMIN;
         1:       return VW'(int'($urandom_range(0, 2000)) - 1000);
         default: return VW'($urandom);
      endcase
   endfunction

   function automatic tis_pkg::req_type rand_request();
      tis_pkg::req_type r;
      int      mode;
      mode = $urandom_range(0, 5);
      r.corner_000 = rand_corner(mode); r.corner_001 = rand_corner(mode);
      r.corner_010 = rand_corner(mode); r.corner_011 = rand_corner(mode);
      r.corner_100 = rand_corner(mode); r.corner_101 = rand_corner(mode);
      r.corner_110 = rand_corner(mode); r.corner_111 = rand_corner(mode);
      r.frac_x = rand_frac(); r.frac_y = rand_frac(); r.frac_z = rand_frac();
      return r;
   endfunction

   // present one request, idling first at random, and hold until accepted
   task automatic send_request(tis_pkg::req_type r);
      while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   function automatic tis_pkg::req_type corners_all(logic signed [VW-1:0] v,
                                                    logic [FW-1:0] f);
      tis_pkg::req_type r;
      r = '{v, v, v, v, v, v, v, v, f, f, f};
      return r;
   endfunction

   initial begin
      tis_pkg::req_type r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, fraction edges, over-range fractions
      send_request(corners_all('0, '0));
      send_request(corners_all(VMAX, FRAC_ONE));
      send_request(corners_all(VMIN, FRAC_ONE >> 1));
      send_request(corners_all('1, FRAC_ONE - FW'(1)));
      send_request(corners_all(VMAX, FRAC_ONE + FW'(1)));   // just over 1.0
      send_request(corners_all(VMIN, '1));                  // all fraction bits
      // alternating extremes, then one corner against all others: largest spread
      r = '{VMAX, VMIN, VMIN, VMAX, VMIN, VMAX, VMAX, VMIN, 0, 0, 0};
      send_request(r);
      r.frac_x = FRAC_ONE; r.frac_y = FRAC_ONE; r.frac_z = FRAC_ONE;
      send_request(r);
      r = '{VMIN, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 0, 0, 0};
      send_request(r);
      r = '{VMAX, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 0, 0, 0};
      send_request(r);
      // one axis over range at a time
      r = corners_all(VW'(100), FRAC_ONE >> 2);
      r.frac_x = FRAC_ONE + FW'(5); send_request(r);
      r = corners_all(VW'(100), FRAC_ONE >> 2);
      r.frac_y = '1; send_request(r);
      r = corners_all(VW'(100), FRAC_ONE >> 2);
      r.frac_z = FRAC_ONE + FW'(1); send_request(r);
      // negative values that truncate toward minus infinity
      r = '{-3, 4, -7, 1, 5, -2, 0, -1, 12345, 54321, 3};
      send_request(r);

      // random phases: no idling, sender idle 64%, 30%, then no idling again
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       idle_pct = 64;
            2:       idle_pct = 30;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < 350; n++)
            send_request(rand_request());
      end
      start <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (tis_pkg::LATENCY + 10) @(posedge clock);

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/tis_pkg.sv
hw/rtl/tis_lerp.sv
hw/rtl/tis_div7_cell.sv
hw/rtl/tis_sqrt_cell.sv
hw/rtl/trilinear_interp_with_spread.sv
hw/rtl/tis_checker.sv
tb/sv/tis_checker.sv
tb/sv/tb.sv
